// ----- hw/rtl/vdtsc_pkg.sv -----
// ----------------------------------------------------------------------------
// vdtsc_pkg
// Constants, field types and the vertical scroll step for the dot timing unit.
// ----------------------------------------------------------------------------
package vdtsc_pkg;

    localparam int unsigned ADDR_W    = 15;
    localparam int unsigned CNT_W     = 9;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 56;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam cnt_t DOTS_LAST      = 9'd340;
    localparam cnt_t VISIBLE_LINES  = 9'd240;
    localparam cnt_t VBLANK_LINE    = 9'd241;
    localparam cnt_t DOT_SNAPSHOT   = 9'd0;
    localparam cnt_t DOT_VBLANK     = 9'd1;
    localparam cnt_t DOT_VERT_STEP  = 9'd256;
    localparam cnt_t DOT_HORI_COPY  = 9'd257;
    localparam cnt_t DOT_VCOPY_LO   = 9'd280;
    localparam cnt_t DOT_VCOPY_HI   = 9'd304;
    localparam cnt_t PRERENDER_RST  = 9'd261;

    localparam addr_t FINE_Y_MASK   = 15'h7000;
    localparam addr_t FINE_Y_ONE    = 15'h1000;
    localparam addr_t COARSE_Y_MASK = 15'h03E0;
    localparam addr_t VERT_NT_BIT   = 15'h0800;
    localparam addr_t HORI_MASK     = 15'h041F;
    localparam addr_t VERT_MASK     = 15'h7BE0;

    localparam logic [4:0] COARSE_Y_WRAP = 5'd29;
    localparam logic [4:0] COARSE_Y_MAX  = 5'd31;

    // register indexes on the configuration port
    localparam logic REG_PRERENDER_LINE = 1'b0;

    // fine y then coarse y step, with nametable flip at row 29
    function automatic addr_t step_vertical(input addr_t a);
        addr_t      r;
        logic [4:0] y;
        r = a;
        y = a[9:5];
        if ((a & FINE_Y_MASK) != FINE_Y_MASK)
        begin
            r = a + FINE_Y_ONE;
        end
        else
        begin
            r = a & ~FINE_Y_MASK;
            if (y == COARSE_Y_WRAP)
            begin
                y = 5'd0;
                r = r ^ VERT_NT_BIT;
            end
            else if (y == COARSE_Y_MAX)
            begin
                y = 5'd0;
            end
            else
            begin
                y = y + 5'd1;
            end
            r = (r & ~COARSE_Y_MASK) | {5'd0, y, 5'd0};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/video_dot_timing_scroll_counter_unit.sv -----
// ----------------------------------------------------------------------------
// video_dot_timing_scroll_counter_unit
// Dot and scanline timing with scroll address tracking for a tile video chip.
// ----------------------------------------------------------------------------
// Each input beat is either a dot tick (tuser low) or a scroll address load
// (tuser high). A dot tick advances a 341-dot scanline counter and a line
// counter that wraps after the programmable pre-render line, toggling the
// odd-frame flag on each wrap. On visible lines the current scroll address is
// captured at dot 0 and a render strobe is given at dot 256; with rendering
// on, the vertical increment happens at dot 256, the horizontal bits are
// copied from the temporary address at dot 257 and the vertical bits at
// pre-render dots 280 to 304. Vblank sets at line 241 dot 1 (raising nmi when
// enabled) and clears at pre-render dot 1. The unit takes one beat per clock:
// the counter and address update is a single level of compare and select
// logic feeding the state registers, and the result beat sits in an output
// register, so a new beat is accepted every cycle while the result side
// takes beats. The pre-render line lives at register address 0 and should
// be written only while no beats are in flight.
module video_dot_timing_scroll_counter_unit #(
    parameter int unsigned PADDR_W = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_value[14:0], temp_address[29:15], show_background[30],
    // show_sprites[31], nmi_enable[32], nmi_request[33], zero pad[39:34]
    input  logic [vdtsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode[0]: 0 dot tick, 1 scroll address load
    input  logic                              s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // nmi[0], vblank[1], line[10:2], dot[19:11], scroll_address[34:20],
    // line_start_address[49:35], render_line[50], odd_frame[51], zero pad[55:52]
    output logic [vdtsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [PADDR_W-1:0]                paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import vdtsc_pkg::*;

    // configuration and timing state
    cnt_t  prerender_reg;
    cnt_t  dot_reg,      dot_next;
    cnt_t  line_reg,     line_next;
    addr_t addr_reg,     addr_next;
    addr_t snap_reg,     snap_next;
    logic  vblank_reg,   vblank_next;
    logic  odd_reg,      odd_next;

    // result beat register
    logic  out_valid_reg;
    logic  [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic  in_beat;
    logic  cfg_write;
    logic  nmi_next;
    logic  strobe_next;

    // unpacked input fields
    logic  mode;
    addr_t load_value;
    addr_t temp_address;
    logic  show_background;
    logic  show_sprites;
    logic  nmi_enable;
    logic  nmi_request;

    // per-dot decode
    logic  visible;
    logic  prerender;
    logic  rendering;
    logic  [CNT_W:0] line_inc;
    logic  [CNT_W:0] dot_inc;

    assign mode            = s_axis_tuser;
    assign load_value      = s_axis_tdata[14:0];
    assign temp_address    = s_axis_tdata[29:15];
    assign show_background = s_axis_tdata[30];
    assign show_sprites    = s_axis_tdata[31];
    assign nmi_enable      = s_axis_tdata[32];
    assign nmi_request     = s_axis_tdata[33];

    // output register frees up when empty or being drained this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // apb: always ready, one register decoded on the word index bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PRERENDER_LINE);
    assign prdata    = (paddr[2] == REG_PRERENDER_LINE) ? {23'd0, prerender_reg} : 32'd0;

    assign visible   = line_reg < VISIBLE_LINES;
    assign prerender = line_reg == prerender_reg;
    assign rendering = show_background || show_sprites;
    assign line_inc  = {1'b0, line_reg} + 10'd1;
    assign dot_inc   = {1'b0, dot_reg} + 10'd1;

    always_comb
    begin
        dot_next    = dot_reg;
        line_next   = line_reg;
        addr_next   = addr_reg;
        snap_next   = snap_reg;
        vblank_next = vblank_reg;
        odd_next    = odd_reg;
        nmi_next    = 1'b0;
        strobe_next = 1'b0;

        if (mode)
        begin
            // load beat only rewrites the scroll address
            addr_next = load_value;
        end
        else
        begin
            nmi_next = nmi_request;
            if (visible && dot_reg == DOT_SNAPSHOT)
            begin
                snap_next = addr_reg;
            end
            if (visible && dot_reg == DOT_VERT_STEP)
            begin
                strobe_next = 1'b1;
                if (rendering)
                begin
                    addr_next = step_vertical(addr_reg);
                end
            end
            // dots 256, 257 and 280..304 never overlap, so each copy sees addr_reg
            if ((visible || prerender) && dot_reg == DOT_HORI_COPY && rendering)
            begin
                addr_next = (addr_reg & ~HORI_MASK) | (temp_address & HORI_MASK);
            end
            if (prerender && dot_reg >= DOT_VCOPY_LO && dot_reg <= DOT_VCOPY_HI && rendering)
            begin
                addr_next = (addr_reg & ~VERT_MASK) | (temp_address & VERT_MASK);
            end
            // clear first, then set, so a pre-render line of 241 ends set
            if (prerender && dot_reg == DOT_VBLANK)
            begin
                vblank_next = 1'b0;
            end
            if (line_reg == VBLANK_LINE && dot_reg == DOT_VBLANK)
            begin
                vblank_next = 1'b1;
                if (nmi_enable)
                begin
                    nmi_next = 1'b1;
                end
            end

            // dot and line advance
            if (dot_inc > {1'b0, DOTS_LAST})
            begin
                dot_next = '0;
                // a 10-bit sum also covers wrap past line 511
                if (line_inc > {1'b0, prerender_reg})
                begin
                    line_next = '0;
                    odd_next  = !odd_reg;
                end
                else
                begin
                    line_next = line_inc[CNT_W-1:0];
                end
            end
            else
            begin
                dot_next = dot_inc[CNT_W-1:0];
            end
        end

        out_data_next = {4'd0, odd_next, strobe_next, snap_next, addr_next,
                         dot_reg, line_reg, vblank_next, nmi_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prerender_reg <= PRERENDER_RST;
            dot_reg       <= '0;
            line_reg      <= PRERENDER_RST;
            addr_reg      <= '0;
            snap_reg      <= '0;
            vblank_reg    <= 1'b0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                prerender_reg <= pwdata[CNT_W-1:0];
            end
            if (in_beat)
            begin
                dot_reg    <= dot_next;
                line_reg   <= line_next;
                addr_reg   <= addr_next;
                snap_reg   <= snap_next;
                vblank_reg <= vblank_next;
                odd_reg    <= odd_next;
            end
            if (in_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // dot counter never leaves the scanline
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dot_reg <= DOTS_LAST)
        else $error("dot counter past end of scanline");

    // render strobe only at dot 256 of a visible line
    a_strobe_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[50]) |->
        (m_axis_tdata[19:11] == DOT_VERT_STEP && m_axis_tdata[10:2] < VISIBLE_LINES))
        else $error("render strobe off its dot");

    // a load beat leaves the counters where they were
    a_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && mode) |=> ($stable(dot_reg) && $stable(line_reg) && $stable(odd_reg)))
        else $error("load beat moved the timing counters");

    // the odd-frame flag only changes when the line counter wraps to zero
    a_odd_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (odd_next != odd_reg)) |=> (line_reg == '0 && dot_reg == '0))
        else $error("odd frame toggled away from frame wrap");

endmodule
